[hw/rtl/alr_pkg.sv]
// Shared constants and codes for the antialiased line rasterizer.
`default_nettype none
package alr_pkg;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
    localparam int SLOPE_BITS = FRAC_BITS + 2;
    localparam int COVER_BITS = 8;
    localparam int COLOR_BITS = 24;
    localparam int CNT_BITS   = $clog2(ACC_BITS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;
endpackage
`default_nettype wire

[hw/rtl/alr_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module alr_div
    import alr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [ACC_BITS-1:0]   dividend,
    input  wire logic [COORD_BITS-1:0] divisor,
    output logic                       done,
    output logic [ACC_BITS-1:0]        quotient
);
    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [CNT_BITS-1:0]   cnt_reg,   cnt_next;
    logic [COORD_BITS-1:0] rem_reg,   rem_next;
    logic [ACC_BITS-1:0]   quo_reg,   quo_next;
    logic [COORD_BITS-1:0] dvs_reg,   dvs_next;
    logic [COORD_BITS:0]   trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[ACC_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            rem_next = fits ? COORD_BITS'(trial - {1'b0, dvs_reg})
                            : trial[COORD_BITS-1:0];
            quo_next = {quo_reg[ACC_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(ACC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

[hw/rtl/alr_col.sv]
// Column formatter: pixel pair, coverage and last flag from the stepper state.
`default_nettype none
module alr_col
    import alr_pkg::*;
(
    input  wire logic                         steep,
    input  wire logic signed [COORD_BITS-1:0] major_pos,
    input  wire logic signed [COORD_BITS-1:0] major_end,
    input  wire logic signed [ACC_BITS-1:0]   minor_acc,
    output logic signed [COORD_BITS-1:0]      first_px,
    output logic signed [COORD_BITS-1:0]      first_py,
    output logic [COVER_BITS-1:0]             first_cover,
    output logic signed [COORD_BITS:0]        second_px,
    output logic signed [COORD_BITS:0]        second_py,
    output logic [COVER_BITS-1:0]             second_cover,
    output logic                              last_column
);
    logic signed [COORD_BITS-1:0] fl;
    logic signed [COORD_BITS:0]   fl1;
    logic signed [COORD_BITS:0]   maj_ext;
    logic [COVER_BITS-1:0]        f8;

    assign fl      = minor_acc[ACC_BITS-1:FRAC_BITS];
    assign fl1     = {fl[COORD_BITS-1], fl} + (COORD_BITS+1)'(1);
    assign maj_ext = {major_pos[COORD_BITS-1], major_pos};
    assign f8      = minor_acc[FRAC_BITS-1 -: COVER_BITS];

    always_comb
    begin
        if (steep)
        begin
            first_px  = fl;
            first_py  = major_pos;
            second_px = fl1;
            second_py = maj_ext;
        end
        else
        begin
            first_px  = major_pos;
            first_py  = fl;
            second_px = maj_ext;
            second_py = fl1;
        end
    end

    assign first_cover  = ~f8;
    assign second_cover = f8;
    assign last_column  = major_pos >= major_end;
endmodule
`default_nettype wire

[hw/rtl/antialiased_line_rasterizer.sv]
// Top level: line setup sequencer, gradient divider and column output register.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | op, start_x, start_y, end_x, end_y, line_color
//   out     | out_valid / out_ready| first_*, second_*, pixel_color, last_column
//
// An accepted step item for an active line puts its column in the output
// register the next cycle. A load with a zero major span needs no divide;
// any other load starts the bit-serial gradient divider, and in_ready is
// low until the slope is stored. It is also low while the output register
// holds a column that is not being taken. Reset clears the line and the output.
`default_nettype none
module antialiased_line_rasterizer
    import alr_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         op,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    input  wire logic [COLOR_BITS-1:0]        line_color,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      first_px,
    output logic signed [COORD_BITS-1:0]      first_py,
    output logic [COVER_BITS-1:0]             first_cover,
    output logic signed [COORD_BITS:0]        second_px,
    output logic signed [COORD_BITS:0]        second_py,
    output logic [COVER_BITS-1:0]             second_cover,
    output logic [COLOR_BITS-1:0]             pixel_color,
    output logic                              last_column
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic                         state_reg,  state_next;
    logic                         active_reg, active_next;
    logic                         steep_reg,  steep_next;
    logic                         neg_reg,    neg_next;
    logic signed [COORD_BITS-1:0] major_pos_reg, major_pos_next;
    logic signed [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic signed [ACC_BITS-1:0]   minor_acc_reg, minor_acc_next;
    logic signed [SLOPE_BITS-1:0] slope_reg,  slope_next;
    logic [COLOR_BITS-1:0]        color_reg,  color_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] fpx_reg, fpy_reg;
    logic [COVER_BITS-1:0]        fcov_reg, scov_reg;
    logic signed [COORD_BITS:0]   spx_reg, spy_reg;
    logic [COLOR_BITS-1:0]        pcol_reg;
    logic                         last_reg;

    logic in_acc, load_acc, step_acc, col_load;

    logic signed [COORD_BITS:0]   dxr, dyr;
    logic [COORD_BITS-1:0]        adx, ady;
    logic                         steep_c, swap_c;
    logic signed [COORD_BITS-1:0] a0, b0, a1, b1, ma0, mb0, ma1, mb1;
    logic signed [COORD_BITS:0]   dmaj, dmin;
    logic [COORD_BITS-1:0]        adm;

    logic                         div_start, div_done;
    logic [ACC_BITS-1:0]          div_q;
    logic [SLOPE_BITS-1:0]        q_mag;

    logic signed [COORD_BITS-1:0] c_fpx, c_fpy;
    logic [COVER_BITS-1:0]        c_fcov, c_scov;
    logic signed [COORD_BITS:0]   c_spx, c_spy;
    logic                         c_last;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_acc   = in_valid && in_ready;
    assign load_acc = in_acc && (op == OP_LOAD);
    assign step_acc = in_acc && (op == OP_STEP);
    assign col_load = step_acc && active_reg;

    // line setup: steepness, axis swap, endpoint order
    assign dxr     = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    assign dyr     = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    assign adx     = COORD_BITS'(dxr[COORD_BITS] ? -dxr : dxr);
    assign ady     = COORD_BITS'(dyr[COORD_BITS] ? -dyr : dyr);
    assign steep_c = ady > adx;
    assign a0      = steep_c ? start_y : start_x;
    assign b0      = steep_c ? start_x : start_y;
    assign a1      = steep_c ? end_y   : end_x;
    assign b1      = steep_c ? end_x   : end_y;
    assign swap_c  = a0 > a1;
    assign ma0     = swap_c ? a1 : a0;
    assign mb0     = swap_c ? b1 : b0;
    assign ma1     = swap_c ? a0 : a1;
    assign mb1     = swap_c ? b0 : b1;
    assign dmaj    = {ma1[COORD_BITS-1], ma1} - {ma0[COORD_BITS-1], ma0};
    assign dmin    = {mb1[COORD_BITS-1], mb1} - {mb0[COORD_BITS-1], mb0};
    assign adm     = COORD_BITS'(dmin[COORD_BITS] ? -dmin : dmin);

    assign div_start = load_acc && (dmaj != '0);
    assign q_mag     = {1'b0, div_q[SLOPE_BITS-2:0]};

    alr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({adm, {FRAC_BITS{1'b0}}}),
        .divisor  (dmaj[COORD_BITS-1:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    alr_col u_col (
        .steep        (steep_reg),
        .major_pos    (major_pos_reg),
        .major_end    (major_end_reg),
        .minor_acc    (minor_acc_reg),
        .first_px     (c_fpx),
        .first_py     (c_fpy),
        .first_cover  (c_fcov),
        .second_px    (c_spx),
        .second_py    (c_spy),
        .second_cover (c_scov),
        .last_column  (c_last)
    );

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        steep_next     = steep_reg;
        neg_next       = neg_reg;
        major_pos_next = major_pos_reg;
        major_end_next = major_end_reg;
        minor_acc_next = minor_acc_reg;
        slope_next     = slope_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load_acc)
                begin
                    steep_next     = steep_c;
                    neg_next       = dmin[COORD_BITS];
                    major_pos_next = ma0;
                    major_end_next = ma1;
                    minor_acc_next = {mb0, {FRAC_BITS{1'b0}}};
                    color_next     = line_color;
                    slope_next     = SLOPE_BITS'(1) <<< FRAC_BITS;
                    if (dmaj != '0)
                    begin
                        active_next = 1'b0;
                        state_next  = S_DIV;
                    end
                    else
                    begin
                        active_next = 1'b1;
                    end
                end
                else if (col_load)
                begin
                    out_valid_next = 1'b1;
                    if (c_last)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        major_pos_next = major_pos_reg + COORD_BITS'(1);
                        minor_acc_next = minor_acc_reg + ACC_BITS'(slope_reg);
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    slope_next  = neg_reg ? -q_mag : q_mag;
                    active_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steep_reg     <= steep_next;
        neg_reg       <= neg_next;
        major_pos_reg <= major_pos_next;
        major_end_reg <= major_end_next;
        minor_acc_reg <= minor_acc_next;
        slope_reg     <= slope_next;
        color_reg     <= color_next;
        if (col_load)
        begin
            fpx_reg  <= c_fpx;
            fpy_reg  <= c_fpy;
            fcov_reg <= c_fcov;
            spx_reg  <= c_spx;
            spy_reg  <= c_spy;
            scov_reg <= c_scov;
            pcol_reg <= color_reg;
            last_reg <= c_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign first_px     = fpx_reg;
    assign first_py     = fpy_reg;
    assign first_cover  = fcov_reg;
    assign second_px    = spx_reg;
    assign second_py    = spy_reg;
    assign second_cover = scov_reg;
    assign pixel_color  = pcol_reg;
    assign last_column  = last_reg;

    a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !in_ready)
        else $error("input taken during gradient divide");

    a_no_line_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !active_reg)
        else $error("line active while gradient pending");

    a_step_gives_column: assert property (@(posedge clk) disable iff (!rst_n)
        col_load |=> out_valid)
        else $error("accepted step produced no column");

    a_load_span_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_DIV))
        else $error("divide start without divide state");
endmodule
`default_nettype wire

[verif/tb_antialiased_line_rasterizer.sv]
// Self-checking testbench for the antialiased line rasterizer.
`timescale 1ns / 1ps
module tb_antialiased_line_rasterizer
    import alr_pkg::*;
    ();

    localparam int ITEM_COUNT    = 1900;
    localparam int CALM_AFTER    = 1500;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic signed [COORD_BITS-1:0] first_px;
        logic signed [COORD_BITS-1:0] first_py;
        logic [COVER_BITS-1:0]        first_cover;
        logic signed [COORD_BITS:0]   second_px;
        logic signed [COORD_BITS:0]   second_py;
        logic [COVER_BITS-1:0]        second_cover;
        logic [COLOR_BITS-1:0]        color;
        logic                         last;
    } column_t;

    class wu_scoreboard;
        bit                    line_active;
        bit                    steep;
        int                    major_pos;
        int                    major_end;
        longint                minor_acc;
        longint                slope;
        logic [COLOR_BITS-1:0] color;
        column_t               expected_cols[$];
        int                    errors;

        function int pending();
            return expected_cols.size();
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            errors++;
        endtask

        function void note_input(input logic op_i,
                                 input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                                 input logic [COLOR_BITS-1:0] col);
            int      ax, ay, bx, by, a0, b0, a1, b1, tmp;
            bit      st;
            longint  fl, f8;
            column_t c;
            if (op_i == OP_LOAD)
            begin
                ax = sx;
                ay = sy;
                bx = ex;
                by = ey;
                st = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
                if (st)
                begin
                    a0 = ay; b0 = ax; a1 = by; b1 = bx;
                end
                else
                begin
                    a0 = ax; b0 = ay; a1 = bx; b1 = by;
                end
                if (a0 > a1)
                begin
                    tmp = a0; a0 = a1; a1 = tmp;
                    tmp = b0; b0 = b1; b1 = tmp;
                end
                if (a1 == a0)
                    slope = longint'(1) <<< FRAC_BITS;
                else
                    slope = (longint'(b1 - b0) * (longint'(1) <<< FRAC_BITS)) / (a1 - a0);
                steep       = st;
                major_pos   = a0;
                major_end   = a1;
                minor_acc   = longint'(b0) <<< FRAC_BITS;
                color       = col;
                line_active = 1'b1;
            end
            else if (line_active)
            begin
                fl = minor_acc >>> FRAC_BITS;
                f8 = ((minor_acc - (fl <<< FRAC_BITS)) >> (FRAC_BITS - COVER_BITS)) & 'hFF;
                c.first_px     = steep ? COORD_BITS'(fl) : COORD_BITS'(major_pos);
                c.first_py     = steep ? COORD_BITS'(major_pos) : COORD_BITS'(fl);
                c.second_px    = steep ? (COORD_BITS+1)'(fl + 1)
                                       : (COORD_BITS+1)'(major_pos);
                c.second_py    = steep ? (COORD_BITS+1)'(major_pos)
                                       : (COORD_BITS+1)'(fl + 1);
                c.first_cover  = COVER_BITS'(255 - f8);
                c.second_cover = COVER_BITS'(f8);
                c.color        = color;
                c.last         = (major_pos >= major_end);
                expected_cols.push_back(c);
                if (c.last)
                    line_active = 1'b0;
                else
                begin
                    major_pos++;
                    minor_acc += slope;
                end
            end
        endfunction

        task compare_field(input string name, input logic signed [31:0] got,
                           input logic signed [31:0] want);
            if (got !== want)
                report($sformatf("%s: got %0d expected %0d", name, got, want));
        endtask

        task check_column(input column_t got);
            column_t want;
            if (expected_cols.size() == 0)
            begin
                report($sformatf("column at (%0d,%0d) with nothing pending",
                                 got.first_px, got.first_py));
                return;
            end
            want = expected_cols.pop_front();
            compare_field("first_px", got.first_px, want.first_px);
            compare_field("first_py", got.first_py, want.first_py);
            compare_field("first_cover", got.first_cover, want.first_cover);
            compare_field("second_px", got.second_px, want.second_px);
            compare_field("second_py", got.second_py, want.second_py);
            compare_field("second_cover", got.second_cover, want.second_cover);
            compare_field("pixel_color", got.color, want.color);
            compare_field("last_column", got.last, want.last);
        endtask
    endclass

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         op = OP_LOAD;
    logic signed [COORD_BITS-1:0] start_x = '0;
    logic signed [COORD_BITS-1:0] start_y = '0;
    logic signed [COORD_BITS-1:0] end_x = '0;
    logic signed [COORD_BITS-1:0] end_y = '0;
    logic [COLOR_BITS-1:0]        line_color = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b1;
    logic signed [COORD_BITS-1:0] first_px;
    logic signed [COORD_BITS-1:0] first_py;
    logic [COVER_BITS-1:0]        first_cover;
    logic signed [COORD_BITS:0]   second_px;
    logic signed [COORD_BITS:0]   second_py;
    logic [COVER_BITS-1:0]        second_cover;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         last_column;

    wu_scoreboard sb;
    bit           idling = 1'b1;
    int           items_sent = 0;
    int           quiet_cycles = 0;

    antialiased_line_rasterizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .line_color   (line_color),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_px     (first_px),
        .first_py     (first_py),
        .first_cover  (first_cover),
        .second_px    (second_px),
        .second_py    (second_py),
        .second_cover (second_cover),
        .pixel_color  (pixel_color),
        .last_column  (last_column)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        column_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.first_px     = first_px;
            got.first_py     = first_py;
            got.first_cover  = first_cover;
            got.second_px    = second_px;
            got.second_py    = second_py;
            got.second_cover = second_cover;
            got.color        = pixel_color;
            got.last         = last_column;
            sb.check_column(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        rand_coord = COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
    endfunction

    function automatic logic [COLOR_BITS-1:0] rand_color();
        rand_color = COLOR_BITS'($urandom_range(0, (1 << COLOR_BITS) - 1));
    endfunction

    function automatic logic signed [COORD_BITS-1:0] nudge_coord(
        input logic signed [COORD_BITS-1:0] base, input int delta);
        int v;
        v = base + delta;
        if (v > (1 << (COORD_BITS - 1)) - 1 || v < -(1 << (COORD_BITS - 1)))
            v = base - delta;
        nudge_coord = COORD_BITS'(v);
    endfunction

    task automatic send_item(input logic op_i,
                             input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                             input logic [COLOR_BITS-1:0] col);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= op_i;
        start_x    <= sx;
        start_y    <= sy;
        end_x      <= ex;
        end_y      <= ey;
        line_color <= col;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(op_i, sx, sy, ex, ey, col);
        items_sent++;
    endtask

    task automatic send_line(input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                             input logic [COLOR_BITS-1:0] col, input int steps);
        send_item(OP_LOAD, sx, sy, ex, ey, col);
        repeat (steps)
            send_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_color());
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
        int d1, d2, span, pick, mode, steps;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(OP_STEP, 0, 0, 0, 0, 24'h000000);
        send_line(-2048, 2047, -2048, 2047, 24'h000000, 2);
        send_line(2047, 2047, 2044, 2045, 24'hFFFFFF, 4);
        send_line(-2048, -2048, -2047, -2045, 24'hA5A5A5, 4);
        send_line(-2048, 2047, 2047, -2048, 24'h5A5A5A, 1);
        send_line(100, -7, 103, -5, 24'h123456, 4);
        send_line(-5, 3, -9, -10, 24'h0F0F0F, 3);
        wait_results();

        while (items_sent < ITEM_COUNT)
        begin
            if (items_sent >= CALM_AFTER)
                idling = 1'b0;
            pick = $urandom_range(0, 99);
            sx = rand_coord();
            sy = rand_coord();
            if (pick < 82)
            begin
                d1 = int'($urandom_range(0, 32)) - 16;
                d2 = int'($urandom_range(0, 32)) - 16;
                if ($urandom_range(0, 9) == 0)
                    d2 = $urandom_range(0, 1) ? d1 : -d1;
                ex = nudge_coord(sx, d1);
                ey = nudge_coord(sy, d2);
                span = (d1 < 0 ? -d1 : d1) > (d2 < 0 ? -d2 : d2) ?
                       (d1 < 0 ? -d1 : d1) : (d2 < 0 ? -d2 : d2);
                mode = $urandom_range(0, 9);
                if (mode == 0)
                    steps = $urandom_range(0, span);
                else if (mode == 1)
                    steps = span + 1 + $urandom_range(1, 2);
                else
                    steps = span + 1;
                send_line(sx, sy, ex, ey, rand_color(), steps);
            end
            else if (pick < 88)
                send_line(sx, sy, rand_coord(), rand_coord(),
                          rand_color(), $urandom_range(1, 20));
            else if (pick < 95)
                send_item(OP_STEP, sx, sy, rand_coord(), rand_coord(), rand_color());
            else
                send_item(OP_LOAD, sx, sy, rand_coord(), rand_coord(), rand_color());
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/alr_pkg.sv
hw/rtl/alr_div.sv
hw/rtl/alr_col.sv
hw/rtl/antialiased_line_rasterizer.sv
verif/tb_antialiased_line_rasterizer.sv
